// File: src/buddy_block_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// shared property forms for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// buddy block allocator package
// flag encodings, status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam logic [1:0] FLAG_NONE = 2'b00;
   localparam logic [1:0] FLAG_FREE = 2'b01;
   localparam logic [1:0] FLAG_FULL = 2'b10;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADSIZE = 2'd2;
   localparam logic [1:0] ST_BADNODE = 2'd3;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic REG_POOL_LOG2    = 1'b0;
   localparam logic REG_HEADER_BYTES = 1'b1;

   typedef enum logic [15:0] {
      S_IDLE = 16'h0001,
      S_A_RD = 16'h0002,
      S_A_EV = 16'h0004,
      S_A_WR = 16'h0008,
      S_A_CL = 16'h0010,
      S_A_CR = 16'h0020,
      S_A_UP = 16'h0040,
      S_A_PL = 16'h0080,
      S_A_PR = 16'h0100,
      S_F_RD = 16'h0200,
      S_F_EV = 16'h0400,
      S_F_M1 = 16'h0800,
      S_F_M2 = 16'h1000,
      S_F_AN = 16'h2000,
      S_F_AW = 16'h4000,
      S_FIN  = 16'h8000
   } state_type;

endpackage

`default_nettype wire

// File: src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32768
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire                     rd_en,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: src/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy block allocator core
// buddy allocator over an implicit binary tree of node flags held in one ram
// ----------------------------------------------------------------------------
// allocate: a node read runs S_A_RD and S_A_EV, a split of a free node adds S_A_WR,
//    clearing the halves of a granted block runs S_A_CL and S_A_CR, backing out of a
//    failed subtree S_A_UP per level, each level up after a grant S_A_UP, S_A_PL, S_A_PR
// free: S_F_RD, S_F_EV, S_F_M1, S_F_M2 per merged level, S_F_RD and S_F_EV for the last
//    node, S_F_AN and S_F_AW per ancestor; S_FIN loads the response once the output
//    is free; bad requests and a root free go straight to S_FIN; one item at a time
// reset: root free, live count zero, registers at defaults; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_block_allocator_core_defines.svh"

module buddy_block_allocator_core #(
   parameter int MAX_POOL_LOG2  = 20,
   parameter int MIN_BLOCK_LOG2 = 6
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,   // request_bytes[20:0], node_index[36:21]
   input  wire  [0:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // block_node[15:0], block_offset[35:16], live_blocks[51:36]
   output logic [1:0]  rsp_tuser,   // status
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW  = MAX_POOL_LOG2 - MIN_BLOCK_LOG2 + 1;
   localparam int IW  = AW + 1;
   localparam int DW  = $clog2(MAX_POOL_LOG2 + 2);
   localparam int SHW = DW + 1;
   localparam int SW  = ((MAX_POOL_LOG2 > 21) ? MAX_POOL_LOG2 : 21) + 3;
   localparam logic [IW-1:0] CAP_IDX = {1'b1, {AW{1'b0}}};
   localparam logic signed [SW-1:0] LEAST = SW'(1) <<< MIN_BLOCK_LOG2;

   bba_pkg::state_type st_ff, st_in;

   logic [4:0]  pool_ff;
   logic [6:0]  hcfg_ff;
   logic [DW-1:0] lg_ff, lg_in, depth_ff, depth_in;
   logic [6:0]  hdr_ff, hdr_in;
   logic signed [SW-1:0] size_ff, size_in, hsum_ff, hsum_in;
   logic [IW-1:0] idx_ff, idx_in, rdi_ff;
   logic        ok_ff, ok_in, lf_ff, lf_in;
   logic [15:0] node_ff, node_in, live_ff, live_in;
   logic [19:0] off_ff, off_in;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  root_ff;
   logic        rsp_valid_ff;
   logic [55:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic          rd_en, wr_en, ram_we;
   logic [IW-1:0] rd_idx, wr_idx;
   logic [1:0]    wr_data, ram_q, flags_q;
   logic          req_acc, cfg_wr, rsp_load;
   logic          live_hold;

   logic [4:0]    eff_lg;
   logic [20:0]   req_size;
   logic [15:0]   req_node;
   logic [AW:0]   node_cnt;
   logic [DW-1:0] maxd;
   logic [SHW-1:0] sh;
   logic signed [SW-1:0] whole, half, span;
   logic          term;
   logic [IW-1:0] pos, parent, left, sib;
   logic [31:0]   pos_sh;

   assign req_acc    = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == bba_pkg::REG_HEADER_BYTES) ?
                       {25'd0, hcfg_ff} : {27'd0, pool_ff};
   assign req_tready = (st_ff == bba_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_load   = (st_ff == bba_pkg::S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign live_hold  = (st_ff == bba_pkg::S_FIN) || (st_ff == bba_pkg::S_IDLE && !req_acc);

   assign eff_lg   = (pool_ff > 5'(MAX_POOL_LOG2)) ? 5'(MAX_POOL_LOG2) : pool_ff;
   assign req_size = req_tdata[20:0];
   assign req_node = req_tdata[36:21];
   assign maxd     = (eff_lg > 5'(MIN_BLOCK_LOG2)) ?
                     DW'(eff_lg - 5'(MIN_BLOCK_LOG2)) : '0;
   assign node_cnt = ((AW+1)'(1) << (maxd + DW'(1))) - (AW+1)'(1);

   // flag ram, root kept in flops
   assign flags_q = (rdi_ff == '0) ? root_ff :
                    (rdi_ff >= CAP_IDX) ? bba_pkg::FLAG_NONE : ram_q;
   assign ram_we  = wr_en && (wr_idx != '0) && (wr_idx < CAP_IDX);

   bba_ram #(
      .WIDTH(2),
      .DEPTH(1 << AW)
   ) u_flags (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_idx[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(ram_q)
   );

   // node geometry
   assign sh     = SHW'(lg_ff) - SHW'(depth_ff);
   assign whole  = SW'(1) <<< sh;
   assign half   = (whole >>> 1) - SW'(hdr_ff >> 1);
   assign span   = half <<< 1;
   assign term   = (hsum_ff > half) || (size_ff > half) || (span <= LEAST);
   assign pos    = idx_ff + IW'(1) - (IW'(1) << depth_ff);
   assign pos_sh = 32'(pos) << sh;
   assign parent = (idx_ff - IW'(1)) >> 1;
   assign left   = (idx_ff << 1) + IW'(1);
   assign sib    = idx_ff[0] ? idx_ff + IW'(1) : idx_ff - IW'(1);

   always_comb begin
      st_in     = st_ff;
      lg_in     = lg_ff;
      hdr_in    = hdr_ff;
      size_in   = size_ff;
      hsum_in   = hsum_ff;
      idx_in    = idx_ff;
      depth_in  = depth_ff;
      ok_in     = ok_ff;
      lf_in     = lf_ff;
      node_in   = node_ff;
      off_in    = off_ff;
      status_in = status_ff;
      live_in   = live_ff;
      rd_en     = 1'b0;
      rd_idx    = idx_ff;
      wr_en     = 1'b0;
      wr_idx    = idx_ff;
      wr_data   = bba_pkg::FLAG_NONE;
      case (st_ff)
         bba_pkg::S_IDLE: begin
            if (req_acc) begin
               lg_in     = DW'(eff_lg);
               hdr_in    = hcfg_ff;
               size_in   = SW'(req_size);
               hsum_in   = SW'(req_size) + SW'(hcfg_ff);
               idx_in    = '0;
               depth_in  = '0;
               node_in   = '0;
               off_in    = '0;
               status_in = bba_pkg::ST_OK;
               if (req_tuser[0] == bba_pkg::OP_ALLOC) begin
                  if (req_size == '0 || SW'(req_size) > (SW'(1) <<< eff_lg)) begin
                     status_in = bba_pkg::ST_BADSIZE;
                     st_in     = bba_pkg::S_FIN;
                  end else begin
                     st_in = bba_pkg::S_A_RD;
                  end
               end else if (32'(req_node) >= 32'(node_cnt)) begin
                  status_in = bba_pkg::ST_BADNODE;
                  st_in     = bba_pkg::S_FIN;
               end else begin
                  if (live_ff != '0) begin
                     live_in = live_ff - 16'd1;
                  end
                  idx_in = IW'(req_node);
                  if (req_node == '0) begin
                     wr_en   = 1'b1;
                     wr_idx  = '0;
                     wr_data = bba_pkg::FLAG_FREE;
                     st_in   = bba_pkg::S_FIN;
                  end else begin
                     st_in = bba_pkg::S_F_RD;
                  end
               end
            end
         end
         bba_pkg::S_A_RD: begin
            rd_en = 1'b1;
            st_in = bba_pkg::S_A_EV;
         end
         bba_pkg::S_A_EV: begin
            if (flags_q[1] || depth_ff > lg_ff) begin
               ok_in = 1'b0;
               st_in = bba_pkg::S_A_UP;
            end else if (term) begin
               if (!flags_q[0]) begin
                  ok_in = 1'b0;
                  st_in = bba_pkg::S_A_UP;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = bba_pkg::FLAG_FULL;
                  live_in = live_ff + 16'd1;
                  node_in = 16'(idx_ff);
                  off_in  = pos_sh[19:0] + 20'(hdr_ff);
                  ok_in   = 1'b1;
                  if (span > LEAST) begin
                     rd_en  = 1'b1;
                     rd_idx = left;
                     st_in  = bba_pkg::S_A_CL;
                  end else begin
                     st_in = bba_pkg::S_A_UP;
                  end
               end
            end else if (flags_q[0]) begin
               wr_en   = 1'b1;
               wr_idx  = left;
               wr_data = bba_pkg::FLAG_FREE;
               st_in   = bba_pkg::S_A_WR;
            end else begin
               idx_in   = left;
               depth_in = depth_ff + DW'(1);
               st_in    = bba_pkg::S_A_RD;
            end
         end
         bba_pkg::S_A_WR: begin
            wr_en    = 1'b1;
            wr_idx   = left + IW'(1);
            wr_data  = bba_pkg::FLAG_FREE;
            idx_in   = left;
            depth_in = depth_ff + DW'(1);
            st_in    = bba_pkg::S_A_RD;
         end
         bba_pkg::S_A_CL: begin
            wr_en   = 1'b1;
            wr_idx  = left;
            wr_data = {flags_q[1], 1'b0};
            rd_en   = 1'b1;
            rd_idx  = left + IW'(1);
            st_in   = bba_pkg::S_A_CR;
         end
         bba_pkg::S_A_CR: begin
            wr_en   = 1'b1;
            wr_idx  = left + IW'(1);
            wr_data = {flags_q[1], 1'b0};
            st_in   = bba_pkg::S_A_UP;
         end
         bba_pkg::S_A_UP: begin
            if (idx_ff == '0) begin
               status_in = ok_ff ? bba_pkg::ST_OK : bba_pkg::ST_NOSPACE;
               st_in     = bba_pkg::S_FIN;
            end else if (!ok_ff && idx_ff[0]) begin
               idx_in = idx_ff + IW'(1);
               st_in  = bba_pkg::S_A_RD;
            end else if (!ok_ff) begin
               idx_in   = parent;
               depth_in = depth_ff - DW'(1);
            end else begin
               rd_en    = 1'b1;
               rd_idx   = idx_ff[0] ? idx_ff : idx_ff - IW'(1);
               idx_in   = parent;
               depth_in = depth_ff - DW'(1);
               st_in    = bba_pkg::S_A_PL;
            end
         end
         bba_pkg::S_A_PL: begin
            lf_in  = flags_q[1];
            rd_en  = 1'b1;
            rd_idx = left + IW'(1);
            st_in  = bba_pkg::S_A_PR;
         end
         bba_pkg::S_A_PR: begin
            wr_en   = 1'b1;
            wr_data = {lf_ff & flags_q[1], 1'b0};
            st_in   = bba_pkg::S_A_UP;
         end
         bba_pkg::S_F_RD: begin
            rd_en  = 1'b1;
            rd_idx = sib;
            st_in  = bba_pkg::S_F_EV;
         end
         bba_pkg::S_F_EV: begin
            wr_en = 1'b1;
            if (flags_q[0]) begin
               wr_data = bba_pkg::FLAG_NONE;
               st_in   = bba_pkg::S_F_M1;
            end else begin
               wr_data = bba_pkg::FLAG_FREE;
               st_in   = bba_pkg::S_F_AN;
            end
         end
         bba_pkg::S_F_M1: begin
            wr_en   = 1'b1;
            wr_idx  = sib;
            wr_data = bba_pkg::FLAG_NONE;
            st_in   = bba_pkg::S_F_M2;
         end
         bba_pkg::S_F_M2: begin
            wr_en   = 1'b1;
            wr_idx  = parent;
            wr_data = bba_pkg::FLAG_FREE;
            idx_in  = parent;
            st_in   = (parent == '0) ? bba_pkg::S_FIN : bba_pkg::S_F_RD;
         end
         bba_pkg::S_F_AN: begin
            if (idx_ff == '0) begin
               st_in = bba_pkg::S_FIN;
            end else begin
               rd_en  = 1'b1;
               rd_idx = parent;
               idx_in = parent;
               st_in  = bba_pkg::S_F_AW;
            end
         end
         bba_pkg::S_F_AW: begin
            wr_en   = 1'b1;
            wr_data = {1'b0, flags_q[0]};
            st_in   = bba_pkg::S_F_AN;
         end
         bba_pkg::S_FIN: begin
            if (rsp_load) begin
               st_in = bba_pkg::S_IDLE;
            end
         end
         default: begin
            st_in = bba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= bba_pkg::S_IDLE;
         pool_ff      <= 5'd20;
         hcfg_ff      <= 7'd16;
         live_ff      <= '0;
         root_ff      <= bba_pkg::FLAG_FREE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         live_ff <= live_in;
         if (cfg_wr) begin
            if (csr_paddr[2] == bba_pkg::REG_POOL_LOG2) begin
               pool_ff <= csr_pwdata[4:0];
            end else begin
               hcfg_ff <= csr_pwdata[6:0];
            end
         end
         if (wr_en && wr_idx == '0) begin
            root_ff <= wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lg_ff     <= lg_in;
      hdr_ff    <= hdr_in;
      size_ff   <= size_in;
      hsum_ff   <= hsum_in;
      idx_ff    <= idx_in;
      depth_ff  <= depth_in;
      ok_ff     <= ok_in;
      lf_ff     <= lf_in;
      node_ff   <= node_in;
      off_ff    <= off_in;
      status_ff <= status_in;
      rdi_ff    <= rd_idx;
      if (rsp_load) begin
         rsp_data_ff <= {4'd0, live_ff, off_ff, node_ff};
         rsp_user_ff <= status_ff;
      end
   end

   `BBA_ASSERT_IMPL(a_no_collision, clock, reset, rd_en && wr_en, rd_idx != wr_idx, "ram clash")
   `BBA_ASSERT_IMPL(a_root_flags, clock, reset, 1'b1, root_ff != 2'b11, "root free and full")
   `BBA_ASSERT_NEXT(a_live_stable, clock, reset, live_hold, $stable(live_ff), "live count moved")

endmodule

`default_nettype wire

// File: dv/tb_buddy_block_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// buddy block allocator testbench
// drives allocate and free requests with random gaps and stalls, predicts
// every response from a local copy of the node tree and compares field by field
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator_core;

   localparam int MAX_LG   = 20;
   localparam int MIN_LG   = 6;
   localparam int NODE_CAP = 2 << (MAX_LG - MIN_LG);

   typedef struct {
      logic        op;
      logic [20:0] size;
      logic [15:0] idx;
   } alloc_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] node;
      logic [19:0] offset;
      logic [15:0] live;
   } alloc_rsp_type;

   typedef struct {
      int unsigned idx;
      logic [1:0]  flags;
      logic [1:0]  known;
   } tree_undo_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [39:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [55:0] rsp_tdata;
   wire  [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   buddy_block_allocator_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // tree copy and configuration
   logic [1:0]    tree_flags [0:NODE_CAP-1];
   logic [1:0]    tree_known [0:NODE_CAP-1];
   int unsigned   live_cnt;
   int unsigned   pool_lg_reg;
   int unsigned   hdr_reg;
   bit            undefined_read;
   tree_undo_type undo_log [$];

   alloc_req_type pending_reqs [$];
   alloc_rsp_type expected_rsps [$];
   int unsigned   granted_nodes [$];
   int            mismatches = 0;
   int            rsp_seen = 0;
   bit            no_idle = 1'b0;

   function automatic int unsigned pool_lg();
      return (pool_lg_reg > MAX_LG) ? MAX_LG : pool_lg_reg;
   endfunction

   function automatic bit flag_rd(int unsigned i, logic [1:0] b);
      if (i >= NODE_CAP) return 1'b0;
      if ((tree_known[i] & b) != b) undefined_read = 1'b1;
      return (tree_flags[i] & b) != 0;
   endfunction

   function automatic void flag_wr(int unsigned i, logic [1:0] b, bit on);
      if (i >= NODE_CAP) return;
      undo_log.push_back('{i, tree_flags[i], tree_known[i]});
      if (on) tree_flags[i] = tree_flags[i] | b;
      else tree_flags[i] = tree_flags[i] & ~b;
      tree_known[i] = tree_known[i] | b;
   endfunction

   function automatic bit grant_block(int unsigned idx, int unsigned depth, longint size,
                                      output int unsigned node, output int unsigned off);
      int unsigned lg;
      longint whole, half, span, hdr, least;
      int unsigned lft, rgt;
      bit was_free, ok;
      lg = pool_lg();
      hdr = hdr_reg;
      least = 64'd1 << MIN_LG;
      lft = 2 * idx + 1;
      rgt = 2 * idx + 2;
      node = 0;
      off = 0;
      if (flag_rd(idx, bba_pkg::FLAG_FULL) || depth > lg) return 1'b0;
      was_free = flag_rd(idx, bba_pkg::FLAG_FREE);
      whole = 64'd1 << (lg - depth);
      half = whole / 2 - hdr / 2;
      span = half * 2;
      if (size + hdr > half || size > half || span <= least) begin
         if (!was_free) return 1'b0;
         flag_wr(idx, bba_pkg::FLAG_FREE, 1'b0);
         flag_wr(idx, bba_pkg::FLAG_FULL, 1'b1);
         live_cnt = (live_cnt + 1) & 16'hFFFF;
         if (span > least) begin
            flag_wr(lft, bba_pkg::FLAG_FREE, 1'b0);
            flag_wr(rgt, bba_pkg::FLAG_FREE, 1'b0);
         end
         node = idx;
         off = ((longint'(idx + 1 - (1 << depth)) * whole) + hdr) & 20'hFFFFF;
         return 1'b1;
      end
      if (was_free) begin
         flag_wr(lft, bba_pkg::FLAG_FREE, 1'b1);
         flag_wr(lft, bba_pkg::FLAG_FULL, 1'b0);
         flag_wr(rgt, bba_pkg::FLAG_FREE, 1'b1);
         flag_wr(rgt, bba_pkg::FLAG_FULL, 1'b0);
      end
      ok = grant_block(lft, depth + 1, size, node, off);
      if (!ok) ok = grant_block(rgt, depth + 1, size, node, off);
      if (ok) begin
         flag_wr(idx, bba_pkg::FLAG_FREE, 1'b0);
         if (flag_rd(lft, bba_pkg::FLAG_FULL) && flag_rd(rgt, bba_pkg::FLAG_FULL))
            flag_wr(idx, bba_pkg::FLAG_FULL, 1'b1);
      end
      return ok;
   endfunction

   function automatic void merge_up(int unsigned idx);
      int unsigned sib, up;
      while (idx != 0) begin
         sib = idx[0] ? idx + 1 : idx - 1;
         up = (idx - 1) / 2;
         if (flag_rd(sib, bba_pkg::FLAG_FREE)) begin
            flag_wr(idx, bba_pkg::FLAG_FREE | bba_pkg::FLAG_FULL, 1'b0);
            flag_wr(sib, bba_pkg::FLAG_FREE | bba_pkg::FLAG_FULL, 1'b0);
            flag_wr(up, bba_pkg::FLAG_FREE, 1'b1);
            flag_wr(up, bba_pkg::FLAG_FULL, 1'b0);
            idx = up;
         end else begin
            flag_wr(idx, bba_pkg::FLAG_FREE, 1'b1);
            flag_wr(idx, bba_pkg::FLAG_FULL, 1'b0);
            while (idx != 0) begin
               idx = (idx - 1) / 2;
               flag_wr(idx, bba_pkg::FLAG_FULL, 1'b0);
            end
            return;
         end
      end
      flag_wr(0, bba_pkg::FLAG_FREE, 1'b1);
      flag_wr(0, bba_pkg::FLAG_FULL, 1'b0);
   endfunction

   // applies one request to the tree copy; rolls back and returns 0 when it
   // would touch a node never written
   function automatic bit predict_alloc(alloc_req_type r, output alloc_rsp_type e);
      int unsigned lg, node, off, maxd, live_save;
      longint cnt;
      tree_undo_type u;
      lg = pool_lg();
      node = 0;
      off = 0;
      live_save = live_cnt;
      undo_log.delete();
      undefined_read = 1'b0;
      e.status = bba_pkg::ST_OK;
      if (r.op == bba_pkg::OP_ALLOC) begin
         if (r.size == 0 || longint'(r.size) > (64'd1 << lg)) e.status = bba_pkg::ST_BADSIZE;
         else if (!grant_block(0, 0, longint'(r.size), node, off)) begin
            e.status = bba_pkg::ST_NOSPACE;
            node = 0;
            off = 0;
         end
      end else begin
         maxd = (lg > MIN_LG) ? lg - MIN_LG : 0;
         cnt = (64'd2 << maxd) - 1;
         if (longint'(r.idx) >= cnt || r.idx >= NODE_CAP) e.status = bba_pkg::ST_BADNODE;
         else begin
            if (live_cnt > 0) live_cnt--;
            merge_up(r.idx);
         end
      end
      if (undefined_read) begin
         while (undo_log.size() > 0) begin
            u = undo_log.pop_back();
            tree_flags[u.idx] = u.flags;
            tree_known[u.idx] = u.known;
         end
         live_cnt = live_save;
         return 1'b0;
      end
      e.node = node[15:0];
      e.offset = off[19:0];
      e.live = live_cnt[15:0];
      return 1'b1;
   endfunction

   function automatic bit queue_request(logic op, int unsigned size, int unsigned idx);
      alloc_req_type r;
      alloc_rsp_type e;
      r.op = op;
      r.size = size[20:0];
      r.idx = idx[15:0];
      if (!predict_alloc(r, e)) return 1'b0;
      if (op == bba_pkg::OP_ALLOC && e.status == bba_pkg::ST_OK) granted_nodes.push_back(e.node);
      pending_reqs.push_back(r);
      expected_rsps.push_back(e);
      return 1'b1;
   endfunction

   function automatic bit random_request();
      int unsigned lg, pick, k, sz;
      lg = pool_lg();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         sz = $urandom_range(1, 1 << $urandom_range(0, lg));
         return queue_request(bba_pkg::OP_ALLOC, sz, $urandom);
      end else if (pick < 80 && granted_nodes.size() > 0) begin
         k = $urandom_range(0, granted_nodes.size() - 1);
         if (!queue_request(bba_pkg::OP_FREE, $urandom, granted_nodes[k])) return 1'b0;
         granted_nodes.delete(k);
         return 1'b1;
      end else if (pick < 88) begin
         return queue_request(bba_pkg::OP_FREE, $urandom,
                              $urandom_range(0, (2 << (lg > MIN_LG ? lg - MIN_LG : 0)) - 2));
      end else if (pick < 93) begin
         return queue_request(bba_pkg::OP_FREE, $urandom, $urandom_range(0, 65535));
      end else begin
         return queue_request(bba_pkg::OP_ALLOC, (pick & 1) ? 0 : $urandom_range(0, 21'h1FFFFF),
                              $urandom);
      end
   endfunction

   task automatic drain_wait();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, int unsigned value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == bba_pkg::REG_POOL_LOG2) pool_lg_reg = value & 5'h1F;
      else hdr_reg = value & 7'h7F;
   endtask

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("response %0d: %s got %0h expected %0h", rsp_seen, what, got, want);
      mismatches++;
   endtask

   // request driver
   int unsigned req_gap = 0;
   always @(posedge clock) begin
      logic nv;
      nv = req_tvalid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            void'(pending_reqs.pop_front());
            nv = 1'b0;
            req_gap = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (!nv) begin
            if (req_gap > 0) req_gap--;
            else if (pending_reqs.size() > 0) begin
               nv = 1'b1;
               req_tdata <= {3'b000, pending_reqs[0].idx, pending_reqs[0].size};
               req_tuser <= pending_reqs[0].op;
            end
         end
         req_tvalid <= nv;
      end
   end

   // response monitor
   int unsigned rsp_wait = 0;
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item", rsp_tuser, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_tuser !== e.status) report_mismatch("status", rsp_tuser, e.status);
               if (rsp_tdata[15:0] !== e.node)
                  report_mismatch("block_node", rsp_tdata[15:0], e.node);
               if (rsp_tdata[35:16] !== e.offset)
                  report_mismatch("block_offset", rsp_tdata[35:16], e.offset);
               if (rsp_tdata[51:36] !== e.live)
                  report_mismatch("live_blocks", rsp_tdata[51:36], e.live);
            end
            if (rsp_seen == 60 || rsp_seen == 900) rsp_wait = 400;
            else rsp_wait = no_idle ? 0 : $urandom_range(0, 19);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned pool_set [7] = '{20, 7, 31, 10, 12, 8, 20};
      int unsigned hdr_set [7] = '{16, 0, 64, 17, 64, 1, 0};
      int n, tries;
      for (int i = 0; i < NODE_CAP; i++) begin
         tree_flags[i] = 2'b00;
         tree_known[i] = 2'b00;
      end
      tree_flags[0] = bba_pkg::FLAG_FREE;
      tree_known[0] = 2'b11;
      live_cnt = 0;
      pool_lg_reg = 20;
      hdr_reg = 16;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed requests at reset settings
      void'(queue_request(bba_pkg::OP_FREE, 0, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 1, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 48, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 49, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 0, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 1048577, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 21'h1FFFFF, 16'hFFFF));
      void'(queue_request(bba_pkg::OP_FREE, 21'h1FFFFF, 16'hFFFF));
      void'(queue_request(bba_pkg::OP_FREE, 0, 32767));
      void'(queue_request(bba_pkg::OP_ALLOC, 524288, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 1048576, 0));
      while (granted_nodes.size() > 0)
         void'(queue_request(bba_pkg::OP_FREE, 0, granted_nodes.pop_front()));
      void'(queue_request(bba_pkg::OP_FREE, 0, 1));
      void'(queue_request(bba_pkg::OP_FREE, 0, 0));
      void'(queue_request(bba_pkg::OP_FREE, 0, 0));
      void'(queue_request(bba_pkg::OP_ALLOC, 1048576, 0));
      void'(queue_request(bba_pkg::OP_FREE, 0, 0));
      drain_wait();

      for (int ph = 0; ph < 7; ph++) begin
         csr_write(bba_pkg::REG_POOL_LOG2, pool_set[ph]);
         csr_write(bba_pkg::REG_HEADER_BYTES, hdr_set[ph]);
         no_idle = (ph % 3 == 1);
         n = 0;
         tries = 0;
         while (n < 200 && tries < 4000) begin
            tries++;
            if (random_request()) n++;
            // sender pause until every response is back
            if (ph == 4 && n == 100) wait (expected_rsps.size() == 0);
         end
         drain_wait();
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: buddy_block_allocator_core.f
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/buddy_block_allocator_core.sv
dv/tb_buddy_block_allocator_core.sv
